// ===== rtl/core/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types, sizes and codes for the 3x3 multi-filter line buffer
// convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

    // Image and kernel geometry.
    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int MAX_FILTERS = 4;
    localparam int KERNEL      = 3;
    localparam int TAPS        = KERNEL * KERNEL;

    // Field widths.
    localparam int PIX_W     = 16;
    localparam int PROD_W    = 2 * PIX_W;
    localparam int ACC_W     = 36;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int DIM_W     = 7;
    localparam int FC_W      = 3;
    localparam int FILT_W    = $clog2(MAX_FILTERS);
    localparam int TAP_SEL_W = 2;
    localparam int TAP_IDX_W = $clog2(TAPS);
    localparam int LINE_W    = (KERNEL - 1) * PIX_W;

    // Stream and configuration port widths.
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = DIM_W;

    // Result queue.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_COUNT = 2'd2;

    // Register reset values and limits.
    localparam logic [DIM_W-1:0] RESET_WIDTH   = DIM_W'(8);
    localparam logic [DIM_W-1:0] RESET_HEIGHT  = DIM_W'(8);
    localparam logic [FC_W-1:0]  RESET_FILTERS = FC_W'(2);
    localparam logic [DIM_W-1:0] DIM_MIN       = DIM_W'(KERNEL);
    localparam logic [DIM_W-1:0] WIDTH_MAX     = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX    = DIM_W'(MAX_HEIGHT);
    localparam logic [FC_W-1:0]  FILTERS_MIN   = FC_W'(1);
    localparam logic [FC_W-1:0]  FILTERS_MAX   = FC_W'(MAX_FILTERS);

    // Input word kinds carried in tuser.
    localparam logic FUNC_COEF  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    typedef logic signed [PIX_W-1:0] pix_t;
    typedef pix_t pix_vec_t [TAPS];

    // Everything that rides along with a result besides its value.
    typedef struct packed {
        logic [FILT_W-1:0] channel;
        logic [ROW_W-1:0]  out_row;
        logic [COL_W-1:0]  out_col;
        logic              last;
    } res_meta_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        res_meta_t               meta;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/lbc_line_mem.sv =====
// ----------------------------------------------------------------------------
// lbc_line_mem
// Line store: one entry per image column holding the pixels of the two
// previous rows. Registered read, with forwarding of a write to the same
// column in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_line_mem
    import lbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [COL_W-1:0]  rd_addr,
    output logic      [LINE_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [COL_W-1:0]  wr_addr,
    input  wire logic [LINE_W-1:0] wr_data
);

    logic [LINE_W-1:0] line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
    end

    // Read port; a write to the same column in this cycle wins.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= line_mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lbc_tap_mem.sv =====
// ----------------------------------------------------------------------------
// lbc_tap_mem
// Filter tap store: one row of nine taps per filter. Single taps are
// written; a whole row is read through registers. Per-tap valid bits
// make never-loaded taps read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_tap_mem
    import lbc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [FILT_W-1:0]    wr_filter,
    input  wire logic [TAP_IDX_W-1:0] wr_tap,
    input  wire pix_t                 wr_data,
    input  wire logic                 rd_en,
    input  wire logic [FILT_W-1:0]    rd_filter,
    output pix_vec_t                  rd_taps
);

    pix_t            tap_mem [MAX_FILTERS][TAPS];
    logic [TAPS-1:0] tap_vld_reg [MAX_FILTERS];
    pix_vec_t        rd_row_reg;
    logic [TAPS-1:0] rd_vld_reg;

    // Tap write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tap_mem[wr_filter][wr_tap] <= wr_data;
        end
    end

    // Valid bits, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int f = 0; f < MAX_FILTERS; f++)
            begin
                tap_vld_reg[f] <= '0;
            end
        end
        else if (wr_en)
        begin
            tap_vld_reg[wr_filter][wr_tap] <= 1'b1;
        end
    end

    // Row read port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= '0;
        end
        else if (rd_en)
        begin
            rd_vld_reg <= tap_vld_reg[rd_filter];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg <= tap_mem[rd_filter];
        end
    end

    // A tap that was never loaded reads as zero.
    always_comb
    begin
        for (int k = 0; k < TAPS; k++)
        begin
            rd_taps[k] = rd_vld_reg[k] ? rd_row_reg[k] : '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lbc_mac.sv =====
// ----------------------------------------------------------------------------
// lbc_mac
// Dot product pipeline: nine parallel 16x16 multiplies followed by a three
// level registered adder tree. Takes one window and filter per cycle and
// never stalls; the caller reserves room for every result in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_mac
    import lbc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire res_meta_t in_meta,
    input  wire pix_vec_t  in_win,
    input  wire pix_vec_t  taps,
    output logic           out_valid,
    output res_t           out_res
);

    localparam int S1_N = (TAPS + 1) / 2;
    localparam int S1_W = PROD_W + 1;
    localparam int S2_W = PROD_W + 2;

    // Valid chain and metadata travel beside the data.
    logic      vld_a_reg, vld_p_reg, vld_s1_reg, vld_s2_reg;
    res_meta_t meta_a_reg, meta_p_reg, meta_s1_reg, meta_s2_reg;

    pix_vec_t                win_a_reg;
    logic signed [PROD_W-1:0] prod_reg [TAPS];
    logic signed [S1_W-1:0]   sum1_reg [S1_N];
    logic signed [S2_W-1:0]   sum2a_reg, sum2b_reg, sum2c_reg;
    logic signed [ACC_W-1:0]  value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg  <= 1'b0;
            vld_p_reg  <= 1'b0;
            vld_s1_reg <= 1'b0;
            vld_s2_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg  <= in_valid;
            vld_p_reg  <= vld_a_reg;
            vld_s1_reg <= vld_p_reg;
            vld_s2_reg <= vld_s1_reg;
        end
    end

    // Capture the window while the tap row is read.
    always_ff @(posedge clk)
    begin
        meta_a_reg  <= in_meta;
        win_a_reg   <= in_win;
        meta_p_reg  <= meta_a_reg;
        meta_s1_reg <= meta_p_reg;
        meta_s2_reg <= meta_s1_reg;
    end

    // Nine products.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < TAPS; k++)
        begin
            prod_reg[k] <= win_a_reg[k] * taps[k];
        end
    end

    // First level: pairwise sums, the odd product passes through.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TAPS / 2; i++)
        begin
            sum1_reg[i] <= S1_W'(prod_reg[2 * i]) + S1_W'(prod_reg[2 * i + 1]);
        end
        sum1_reg[S1_N - 1] <= S1_W'(prod_reg[TAPS - 1]);
    end

    // Second level: three partial sums.
    always_ff @(posedge clk)
    begin
        sum2a_reg <= S2_W'(sum1_reg[0]) + S2_W'(sum1_reg[1]);
        sum2b_reg <= S2_W'(sum1_reg[2]) + S2_W'(sum1_reg[3]);
        sum2c_reg <= S2_W'(sum1_reg[4]);
    end

    // Final sum; nine Q16.16 products always fit the 36 bit result.
    always_ff @(posedge clk)
    begin
        value_reg <= ACC_W'(sum2a_reg) + ACC_W'(sum2b_reg) + ACC_W'(sum2c_reg);
    end

    logic vld_out_reg;
    res_meta_t meta_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_out_reg <= 1'b0;
        end
        else
        begin
            vld_out_reg <= vld_s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        meta_out_reg <= meta_s2_reg;
    end

    assign out_valid     = vld_out_reg;
    assign out_res.value = value_reg;
    assign out_res.meta  = meta_out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lbc_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lbc_out_fifo
// Result queue between the dot product pipeline and the output stream.
// Space is reserved upstream before a result enters the pipeline, so a
// push never finds the queue full.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_out_fifo
    import lbc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire res_t push_data,
    input  wire logic pop,
    output logic      out_valid,
    output res_t      out_data
);

    res_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = fifo_mem[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== rtl/core/line_buffer_conv2d.sv =====
// ----------------------------------------------------------------------------
// line_buffer_conv2d
// Valid 3x3 convolution of a raster-order image with up to four filters.
// ----------------------------------------------------------------------------
// Coefficient words (tuser 0) load one Q8.8 tap into the tap store; pixel
// words (tuser 1) shift through a two-row line store into a 3x3 window.
// A pixel that completes a window produces filter_count result words, one per
// filter in filter order, with tlast on the final one. Pixels are taken one
// per cycle unless the filter issue stage is busy: a pixel that completes a
// window holds that stage until all filter_count filters (1 to 4) are issued,
// reading one filter's row of taps per cycle from the tap store while the
// result queue has room. Coefficient words are taken only once every pixel
// ahead of them has read its taps. The output side is parted by an
// eight-word result queue, so input continues while results wait to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module line_buffer_conv2d
    import lbc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration write port.
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    // Input stream.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata, from bit 0: filter_index[1:0], tap_row[3:2], tap_col[5:4],
    // coefficient[21:6], pixel[37:22], zero fill[39:38].
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // s_tuser: func (0 coefficient, 1 pixel).
    input  wire logic                 s_tuser,
    // Result stream.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata, from bit 0: out_row[5:0], out_col[11:6], value[47:12].
    output logic [M_DATA_W-1:0]       m_tdata,
    // m_tuser: channel[1:0].
    output logic [FILT_W-1:0]         m_tuser,
    output logic                      m_tlast
);

    localparam logic [COL_W-1:0] COL_EDGE = COL_W'(KERNEL - 1);
    localparam logic [ROW_W-1:0] ROW_EDGE = ROW_W'(KERNEL - 1);
    localparam logic [TAP_SEL_W-1:0] TAP_SEL_MAX = TAP_SEL_W'(KERNEL - 1);

    // ------------------------------------------------------------------
    // Configuration registers and their clamped values.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] width_raw_reg, height_raw_reg;
    logic [FC_W-1:0]  filters_raw_reg;
    logic [DIM_W-1:0] img_w, img_h;
    logic [FC_W-1:0]  num_filters;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_raw_reg   <= RESET_WIDTH;
            height_raw_reg  <= RESET_HEIGHT;
            filters_raw_reg <= RESET_FILTERS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_raw_reg   <= cfg_data;
                REG_IMAGE_HEIGHT: height_raw_reg  <= cfg_data;
                REG_FILTER_COUNT: filters_raw_reg <= cfg_data[FC_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        img_w = (width_raw_reg < DIM_MIN) ? DIM_MIN :
                (width_raw_reg > WIDTH_MAX) ? WIDTH_MAX : width_raw_reg;
        img_h = (height_raw_reg < DIM_MIN) ? DIM_MIN :
                (height_raw_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_raw_reg;
        num_filters = (filters_raw_reg < FILTERS_MIN) ? FILTERS_MIN :
                      (filters_raw_reg > FILTERS_MAX) ? FILTERS_MAX : filters_raw_reg;
    end

    // ------------------------------------------------------------------
    // Input word fields.
    // ------------------------------------------------------------------
    logic [FILT_W-1:0]    in_filter;
    logic [TAP_SEL_W-1:0] in_tap_row, in_tap_col;
    pix_t                 in_coef, in_pixel;
    logic                 in_func;
    logic [TAP_IDX_W-1:0] in_tap_idx;
    logic                 tap_in_range;

    assign in_func      = s_tuser;
    assign in_filter    = s_tdata[1:0];
    assign in_tap_row   = s_tdata[3:2];
    assign in_tap_col   = s_tdata[5:4];
    assign in_coef      = s_tdata[21:6];
    assign in_pixel     = s_tdata[37:22];
    assign in_tap_idx   = TAP_IDX_W'(in_tap_row) * TAP_IDX_W'(KERNEL) + TAP_IDX_W'(in_tap_col);
    assign tap_in_range = (in_tap_row <= TAP_SEL_MAX) && (in_tap_col <= TAP_SEL_MAX);

    // ------------------------------------------------------------------
    // Pipeline control.
    // ------------------------------------------------------------------
    logic             s1_valid_reg, s1_emit_reg;
    pix_t             s1_pixel_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;

    logic              s2_busy_reg;
    logic [FILT_W-1:0] s2_filter_reg;
    logic [COL_W-1:0]  s2_col_reg;
    logic [ROW_W-1:0]  s2_row_reg;
    pix_vec_t          win_reg;

    logic [CNT_W-1:0] credit_reg, credit_next;

    logic s2_issue, s2_last, s2_free, s1_adv;
    logic pix_ready, coef_ready;
    logic pix_accept, coef_accept;
    logic out_pop;

    assign s2_issue  = s2_busy_reg && (credit_reg < CNT_W'(FIFO_DEPTH));
    assign s2_last   = (FC_W'(s2_filter_reg) + 1'b1) == num_filters;
    assign s2_free   = !s2_busy_reg || (s2_issue && s2_last);
    assign s1_adv    = s1_valid_reg && s2_free;
    assign pix_ready  = !s1_valid_reg || s1_adv;
    assign coef_ready = !s1_valid_reg && !s2_busy_reg;
    assign s_tready   = (in_func == FUNC_PIXEL) ? pix_ready : coef_ready;
    assign pix_accept  = s_tvalid && s_tready && (in_func == FUNC_PIXEL);
    assign coef_accept = s_tvalid && s_tready && (in_func == FUNC_COEF);

    // ------------------------------------------------------------------
    // Row and column counters.
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg, col_next, cur_col;
    logic [ROW_W-1:0] row_reg, row_next, cur_row;
    logic [DIM_W-1:0] col_pre, row_pre, col_inc, row_inc;
    logic             cur_emit;

    always_comb
    begin
        // Wrap first if a counter already sits at or beyond its limit.
        col_pre = DIM_W'(col_reg);
        row_pre = DIM_W'(row_reg);
        if (col_pre >= img_w)
        begin
            col_pre = '0;
            row_pre = row_pre + 1'b1;
        end
        if (row_pre >= img_h)
        begin
            row_pre = '0;
        end
        cur_col = col_pre[COL_W-1:0];
        cur_row = row_pre[ROW_W-1:0];

        // Advance past this pixel.
        col_inc = col_pre + 1'b1;
        row_inc = row_pre;
        if (col_inc >= img_w)
        begin
            col_inc = '0;
            row_inc = row_pre + 1'b1;
            if (row_inc >= img_h)
            begin
                row_inc = '0;
            end
        end

        col_next = pix_accept ? col_inc[COL_W-1:0] : col_reg;
        row_next = pix_accept ? row_inc[ROW_W-1:0] : row_reg;
        cur_emit = (cur_row >= ROW_EDGE) && (cur_col >= COL_EDGE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store read in flight.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pix_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_pixel_reg <= in_pixel;
            s1_col_reg   <= cur_col;
            s1_row_reg   <= cur_row;
            s1_emit_reg  <= cur_emit;
        end
    end

    logic [LINE_W-1:0] line_rd, line_wr;
    pix_vec_t          column;

    lbc_line_mem u_line_mem (
        .clk     (clk),
        .rd_en   (pix_accept),
        .rd_addr (cur_col),
        .rd_data (line_rd),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (line_wr)
    );

    // New window column, oldest row on top; each row moves one line down.
    assign line_wr = {line_rd[LINE_W-PIX_W-1:0], s1_pixel_reg};

    always_comb
    begin
        for (int k = 0; k < TAPS; k++)
        begin
            column[k] = '0;
        end
        for (int k = 0; k < KERNEL - 1; k++)
        begin
            column[k] = line_rd[(KERNEL - 1 - k) * PIX_W - 1 -: PIX_W];
        end
        column[KERNEL - 1] = s1_pixel_reg;
    end

    // ------------------------------------------------------------------
    // Stage 2: sliding window and per-filter issue.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (s1_adv)
        begin
            for (int r = 0; r < KERNEL; r++)
            begin
                for (int j = 0; j < KERNEL - 1; j++)
                begin
                    win_reg[r * KERNEL + j] <= win_reg[r * KERNEL + j + 1];
                end
                win_reg[r * KERNEL + KERNEL - 1] <= column[r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_busy_reg   <= 1'b0;
            s2_filter_reg <= '0;
        end
        else if (s1_adv)
        begin
            s2_busy_reg   <= s1_emit_reg;
            s2_filter_reg <= '0;
        end
        else if (s2_issue)
        begin
            if (s2_last)
            begin
                s2_busy_reg <= 1'b0;
            end
            s2_filter_reg <= s2_filter_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_col_reg <= s1_col_reg;
            s2_row_reg <= s1_row_reg;
        end
    end

    res_meta_t issue_meta;

    always_comb
    begin
        issue_meta.channel = s2_filter_reg;
        issue_meta.out_row = s2_row_reg - ROW_EDGE;
        issue_meta.out_col = s2_col_reg - COL_EDGE;
        issue_meta.last    = s2_last;
    end

    // Results reserved in the queue, counting those still in the pipeline.
    assign credit_next = credit_reg + CNT_W'(s2_issue) - CNT_W'(out_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    // ------------------------------------------------------------------
    // Tap store, dot product pipeline and result queue.
    // ------------------------------------------------------------------
    pix_vec_t taps;
    logic     mac_valid;
    res_t     mac_res;
    res_t     head;

    lbc_tap_mem u_tap_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (coef_accept && tap_in_range),
        .wr_filter (in_filter),
        .wr_tap    (in_tap_idx),
        .wr_data   (in_coef),
        .rd_en     (s2_issue),
        .rd_filter (s2_filter_reg),
        .rd_taps   (taps)
    );

    lbc_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_issue),
        .in_meta   (issue_meta),
        .in_win    (win_reg),
        .taps      (taps),
        .out_valid (mac_valid),
        .out_res   (mac_res)
    );

    lbc_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mac_valid),
        .push_data (mac_res),
        .pop       (out_pop),
        .out_valid (m_tvalid),
        .out_data  (head)
    );

    assign out_pop = m_tvalid && m_tready;
    assign m_tdata = {head.value, head.meta.out_col, head.meta.out_row};
    assign m_tuser = head.meta.channel;
    assign m_tlast = head.meta.last;

endmodule

`default_nettype wire
